/* design/btgr_pkg.sv */
// ----------------------------------------------------------------------------
// btgr_pkg
// Shared types and constants for the 8x16 bitmap glyph renderer: command
// codes, register indexes, beat payloads and the controller/datapath link.
// ----------------------------------------------------------------------------
package btgr_pkg;

    // Glyph geometry that does not vary
    localparam int unsigned GLYPH_COLS = 8;
    localparam int unsigned LINE_STEP  = 16;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOUR         = 3'd0,
        REG_SCREEN_WIDTH   = 3'd1,
        REG_SCREEN_HEIGHT  = 3'd2,
        REG_SCANLINE_PITCH = 3'd3,
        REG_GLYPH_STRIDE   = 3'd4
    } cfg_reg_t;

    // Command codes carried in the input beat
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_DRAW = 2'd1,
        CMD_MOVE = 2'd2
    } command_t;

    // Input beat
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_code;
        logic [11:0] font_address;
        logic [7:0]  font_byte;
        logic [11:0] new_x;
        logic [12:0] new_y;
    } in_item_t;

    // Output beat: one framebuffer row write
    typedef struct packed {
        logic [25:0] pixel_index;
        logic [7:0]  lane_mask;
        logic [31:0] pixel_colour;
        logic        off_screen;
        logic        last;
    } out_item_t;

    // Controller state
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DRAW = 1'b1
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // write a font byte
        logic move;   // set the cursor
        logic draw;   // start a glyph: set up row walk, advance cursor
        logic issue;  // read one glyph row
        logic last;   // the issued row is the final one
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic slot_free;  // a row read may be issued this cycle
    } dp_stat_t;

endpackage

/* design/bitmap_text_glyph_renderer.sv */
// ----------------------------------------------------------------------------
// bitmap_text_glyph_renderer
// Text renderer for 8-column bitmap fonts: loads a font store byte by byte,
// keeps a pixel cursor and turns each drawn character into one masked
// framebuffer row write per glyph row.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------
//   in      | input     | in_valid/in_stall  | in_item  (btgr_pkg::in_item_t)
//   out     | output    | out_valid/out_stall| out_item (btgr_pkg::out_item_t)
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Load, move and unknown commands are taken while idle. A draw is taken, then
// issues GLYPH_ROWS row reads from the single-port font memory, one glyph row
// per cycle while the pending stage has room; rows pass through the read
// register and pending stage to out_item. out_stall holds the row pipeline and
// delays the remaining reads. Reset clears the cursor and sets registers to
// their defaults; the font memory is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
module bitmap_text_glyph_renderer #(
    parameter int unsigned FONT_BYTES = 4096,
    parameter int unsigned GLYPH_ROWS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [btgr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [btgr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  btgr_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output btgr_pkg::out_item_t                 out_item
);

    btgr_pkg::ctl_cmd_t ctl_cmd;
    btgr_pkg::dp_stat_t dp_stat;

    // Sequencer
    btgr_ctrl #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (in_item.command),
        .in_stall (in_stall),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    // Datapath
    btgr_datapath #(
        .FONT_BYTES (FONT_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (ctl_cmd),
        .stat      (dp_stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

`ifndef SYNTH
    // A draw beat keeps the input side busy on the next cycle
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_item.command == btgr_pkg::CMD_DRAW) |=> in_stall)
        else $error("input taken right after a draw beat");

    // Row reads only go out when the pending stage has room
    a_issue_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.issue |-> dp_stat.slot_free)
        else $error("row read issued with pending stage full");

    // No input beat is taken while rows are being read
    a_issue_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.issue |-> in_stall)
        else $error("input accepted during row reads");
`endif

endmodule

/* design/btgr_ctrl.sv */
// ----------------------------------------------------------------------------
// btgr_ctrl
// Command decode and row sequencer. Takes one input beat while idle and,
// for a draw, walks the glyph rows, issuing one row read per free slot.
// ----------------------------------------------------------------------------
module btgr_ctrl #(
    parameter int unsigned GLYPH_ROWS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          command,
    output logic                in_stall,
    input  btgr_pkg::dp_stat_t  stat,
    output btgr_pkg::ctl_cmd_t  cmd
);

    localparam int unsigned ROW_W = $clog2(GLYPH_ROWS);

    btgr_pkg::ctrl_state_t state_reg, state_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic                  accept;
    logic                  final_row;

    assign accept    = in_valid && (state_reg == btgr_pkg::ST_IDLE);
    assign final_row = (row_reg == ROW_W'(GLYPH_ROWS - 1));

    // State and row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btgr_pkg::ST_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            btgr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    cmd.load = (command == btgr_pkg::CMD_LOAD);
                    cmd.move = (command == btgr_pkg::CMD_MOVE);
                    cmd.draw = (command == btgr_pkg::CMD_DRAW);
                    if (command == btgr_pkg::CMD_DRAW)
                    begin
                        state_next = btgr_pkg::ST_DRAW;
                        row_next   = '0;
                    end
                end
            end
            btgr_pkg::ST_DRAW:
            begin
                // Issue a row whenever the pending stage can take it
                if (stat.slot_free)
                begin
                    cmd.issue = 1'b1;
                    cmd.last  = final_row;
                    if (final_row)
                    begin
                        state_next = btgr_pkg::ST_IDLE;
                        row_next   = '0;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = btgr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/btgr_datapath.sv */
// ----------------------------------------------------------------------------
// btgr_datapath
// Configuration registers, cursor, single-port font memory, row address and
// pixel index walkers, one pending row stage and the output register.
// ----------------------------------------------------------------------------
module btgr_datapath #(
    parameter int unsigned FONT_BYTES = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [btgr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [btgr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  btgr_pkg::in_item_t                  in_item,
    input  btgr_pkg::ctl_cmd_t                  cmd,
    output btgr_pkg::dp_stat_t                  stat,
    output logic                                out_valid,
    input  logic                                out_stall,
    output btgr_pkg::out_item_t                 out_item
);

    // FONT_BYTES must be a power of two (the block does not check it); addresses wrap at its width
    localparam int unsigned FA_W = $clog2(FONT_BYTES);

    // Configuration registers
    logic [31:0] colour_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [13:0] pitch_reg;
    logic [4:0]  stride_reg;

    // Cursor
    logic [11:0] cursor_x_reg;
    logic [12:0] cursor_y_reg;

    // Row walkers
    logic [FA_W-1:0] rd_addr_reg;
    logic [25:0]     idx_reg;
    logic [13:0]     py_reg;

    // Font memory and its read register
    logic [7:0] font_mem [FONT_BYTES];
    logic [7:0] rd_data_reg;

    // Pending row stage
    logic        p_valid_reg, p_valid_next;
    logic [25:0] p_idx_reg;
    logic        p_off_reg;
    logic        p_last_reg;
    logic        p_move;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    btgr_pkg::out_item_t  out_item_reg;

    // Draw set-up arithmetic
    logic [13:0] load_addr_ext;
    logic        load_ok;
    logic [12:0] base_prod;
    logic [13:0] base_ext;
    logic [26:0] start_prod;
    logic [25:0] start_idx;
    logic [12:0] nx;
    logic [13:0] nx_end;
    logic        wrap;

    assign load_addr_ext = 14'(in_item.font_address);
    assign load_ok       = (load_addr_ext < 14'(FONT_BYTES));
    assign base_prod     = 13'(in_item.char_code) * 13'(stride_reg);
    assign base_ext      = 14'(base_prod);
    assign start_prod    = 27'(cursor_y_reg) * 27'(pitch_reg);
    assign start_idx     = 26'(start_prod + 27'(cursor_x_reg));
    assign nx            = 13'(cursor_x_reg) + 13'(btgr_pkg::GLYPH_COLS);
    assign nx_end        = 14'(nx) + 14'(btgr_pkg::GLYPH_COLS);
    assign wrap          = (nx_end > 14'(width_reg));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg <= 32'hFFFF_FFFF;
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            pitch_reg  <= 14'd640;
            stride_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                btgr_pkg::REG_COLOUR:         colour_reg <= cfg_data;
                btgr_pkg::REG_SCREEN_WIDTH:   width_reg  <= cfg_data[12:0];
                btgr_pkg::REG_SCREEN_HEIGHT:  height_reg <= cfg_data[12:0];
                btgr_pkg::REG_SCANLINE_PITCH: pitch_reg  <= cfg_data[13:0];
                btgr_pkg::REG_GLYPH_STRIDE:   stride_reg <= cfg_data[4:0];
                default:                      ;
            endcase
        end
    end

    // Cursor: set on move, advance one cell on draw, wrap to next text line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else if (cmd.move)
        begin
            cursor_x_reg <= in_item.new_x;
            cursor_y_reg <= in_item.new_y;
        end
        else if (cmd.draw)
        begin
            if (wrap)
            begin
                cursor_x_reg <= '0;
                cursor_y_reg <= cursor_y_reg + 13'(btgr_pkg::LINE_STEP);
            end
            else
            begin
                cursor_x_reg <= nx[11:0];
            end
        end
    end

    // Row walkers: load on draw, step on each issued row
    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            rd_addr_reg <= base_ext[FA_W-1:0];
            idx_reg     <= start_idx;
            py_reg      <= 14'(cursor_y_reg);
        end
        else if (cmd.issue)
        begin
            rd_addr_reg <= rd_addr_reg + FA_W'(1);
            idx_reg     <= idx_reg + 26'(pitch_reg);
            py_reg      <= py_reg + 14'd1;
        end
    end

    // Font memory: one access per cycle, write on load, read on issue
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            font_mem[load_addr_ext[FA_W-1:0]] <= in_item.font_byte;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= font_mem[rd_addr_reg];
        end
    end

    // Pending stage moves on when the output register is empty or drains
    assign p_move         = p_valid_reg && (!out_valid_reg || !out_stall);
    assign stat.slot_free = !p_valid_reg || p_move;

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (cmd.issue)
        begin
            p_valid_next = 1'b1;
        end
        else if (p_move)
        begin
            p_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (p_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture row side data alongside the memory read
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            p_idx_reg  <= idx_reg;
            p_off_reg  <= (py_reg >= 14'(height_reg));
            p_last_reg <= cmd.last;
        end
    end

    // Load the output beat
    always_ff @(posedge clk)
    begin
        if (p_move)
        begin
            out_item_reg.pixel_index  <= p_idx_reg;
            out_item_reg.lane_mask    <= rd_data_reg;
            out_item_reg.pixel_colour <= colour_reg;
            out_item_reg.off_screen   <= p_off_reg;
            out_item_reg.last         <= p_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: bitmap_text_glyph_renderer
// Drives font loads, cursor moves and glyph draws through the valid/stall
// input channel and keeps its own copy of the font store, the cursor and the
// registers. Every row write that leaves the block is matched against the
// oldest predicted row. Register sets are changed between phases while the
// block is idle. The sender runs in bursts and the receiver stalls on
// changing patterns.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned FONT_BYTES = 4096;
    localparam int unsigned GLYPH_ROWS = 16;

    // Command code three carries no operation and is dropped by the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Tracks font, cursor and registers; holds the rows each draw must emit
    class glyph_tracker;
        btgr_pkg::out_item_t rows_due[$];
        logic [7:0]  font [FONT_BYTES];
        bit          loaded [FONT_BYTES];
        logic [11:0] cur_x;
        logic [12:0] cur_y;
        logic [31:0] colour;
        logic [12:0] width;
        logic [12:0] height;
        logic [13:0] pitch;
        logic [4:0]  stride;
        int          errors;
        int          rows_seen;
        int          draws;
        int          loads;
        int          moves;

        function new();
            cur_x     = '0;
            cur_y     = '0;
            colour    = 32'hFFFF_FFFF;
            width     = 13'd640;
            height    = 13'd480;
            pitch     = 14'd640;
            stride    = 5'd16;
            errors    = 0;
            rows_seen = 0;
            draws     = 0;
            loads     = 0;
            moves     = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_config(btgr_pkg::cfg_reg_t r, logic [31:0] v);
            case (r)
                btgr_pkg::REG_COLOUR:         colour = v;
                btgr_pkg::REG_SCREEN_WIDTH:   width  = v[12:0];
                btgr_pkg::REG_SCREEN_HEIGHT:  height = v[12:0];
                btgr_pkg::REG_SCANLINE_PITCH: pitch  = v[13:0];
                btgr_pkg::REG_GLYPH_STRIDE:   stride = v[4:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted input beat and queue the rows it produces
        function void take_command(btgr_pkg::in_item_t it);
            btgr_pkg::out_item_t row_w;
            int unsigned addr;
            int unsigned py;
            logic [63:0] idx;
            logic [12:0] nx;
            case (it.command)
                btgr_pkg::CMD_LOAD:
                begin
                    if (it.font_address < FONT_BYTES)
                    begin
                        font[it.font_address]   = it.font_byte;
                        loaded[it.font_address] = 1'b1;
                    end
                    loads++;
                end
                btgr_pkg::CMD_MOVE:
                begin
                    cur_x = it.new_x;
                    cur_y = it.new_y;
                    moves++;
                end
                btgr_pkg::CMD_DRAW:
                begin
                    for (int row = 0; row < GLYPH_ROWS; row++)
                    begin
                        addr = (int'(it.char_code) * int'(stride) + row) % FONT_BYTES;
                        py   = int'(cur_y) + row;
                        idx  = 64'(cur_x) + 64'(py) * 64'(pitch);
                        row_w.pixel_index  = idx[25:0];
                        row_w.lane_mask    = font[addr];
                        row_w.pixel_colour = colour;
                        row_w.off_screen   = (py >= int'(height));
                        row_w.last         = (row == GLYPH_ROWS - 1);
                        rows_due.push_back(row_w);
                    end
                    // advance one cell, wrap to the next text line past the width
                    nx = {1'b0, cur_x} + 13'(btgr_pkg::GLYPH_COLS);
                    if (int'(nx) + btgr_pkg::GLYPH_COLS > int'(width))
                    begin
                        cur_x = '0;
                        cur_y = cur_y + 13'(btgr_pkg::LINE_STEP);
                    end
                    else
                    begin
                        cur_x = nx[11:0];
                    end
                    draws++;
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted output beat with the oldest predicted row
        task match_row(btgr_pkg::out_item_t got);
            btgr_pkg::out_item_t want;
            rows_seen++;
            if (rows_due.size() == 0)
            begin
                report($sformatf("row %0d arrived with none pending (index %h)",
                                 rows_seen, got.pixel_index));
                return;
            end
            want = rows_due.pop_front();
            if (got.pixel_index !== want.pixel_index)
                report($sformatf("row %0d pixel_index %h, want %h",
                                 rows_seen, got.pixel_index, want.pixel_index));
            if (got.lane_mask !== want.lane_mask)
                report($sformatf("row %0d lane_mask %h, want %h",
                                 rows_seen, got.lane_mask, want.lane_mask));
            if (got.pixel_colour !== want.pixel_colour)
                report($sformatf("row %0d pixel_colour %h, want %h",
                                 rows_seen, got.pixel_colour, want.pixel_colour));
            if (got.off_screen !== want.off_screen)
                report($sformatf("row %0d off_screen %b, want %b",
                                 rows_seen, got.off_screen, want.off_screen));
            if (got.last !== want.last)
                report($sformatf("row %0d last %b, want %b",
                                 rows_seen, got.last, want.last));
        endtask
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [btgr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [btgr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    btgr_pkg::in_item_t              in_item   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    btgr_pkg::out_item_t             out_item;

    glyph_tracker book;
    int           items_sent = 0;
    int           burst_left = 0;
    int           settings   = 0;
    int           stall_mode = 0;
    int           stall_hold = 0;
    int           tick       = 0;
    logic [7:0]   recent[$];

    bitmap_text_glyph_renderer #(
        .FONT_BYTES (FONT_BYTES),
        .GLYPH_ROWS (GLYPH_ROWS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    // Check output beats and stall on a pattern that changes now and then
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                book.match_row(out_item);
            if (stall_hold == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_hold <= $urandom_range(30, 200);
            end
            else
            begin
                stall_hold <= stall_hold - 1;
            end
            tick <= tick + 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((tick % 5) < 2);
            endcase
        end
    end

    function automatic btgr_pkg::in_item_t rand_item();
        btgr_pkg::in_item_t it;
        it.command      = 2'($urandom);
        it.char_code    = 8'($urandom);
        it.font_address = 12'($urandom);
        it.font_byte    = 8'($urandom);
        it.new_x        = 12'($urandom);
        it.new_y        = 13'($urandom);
        return it;
    endfunction

    // Offer one beat and hold it until the block takes it
    task automatic push_item(btgr_pkg::in_item_t it);
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.take_command(it);
        if (it.command != CMD_UNUSED)
            items_sent++;
    endtask

    // Keep valid up inside a burst, drop it for a random gap between bursts
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            in_item  <= rand_item();
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 8);
        end
    endtask

    // Hold the sender until every pending row is out, then settle
    task automatic drain(int settle);
        in_valid <= 1'b0;
        while (book.rows_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_regs(logic [31:0] c, logic [31:0] w, logic [31:0] h,
                              logic [31:0] p, logic [31:0] s);
        btgr_pkg::cfg_reg_t order [5];
        logic [31:0]        v [5];
        order = '{btgr_pkg::REG_COLOUR, btgr_pkg::REG_SCREEN_WIDTH,
                  btgr_pkg::REG_SCREEN_HEIGHT, btgr_pkg::REG_SCANLINE_PITCH,
                  btgr_pkg::REG_GLYPH_STRIDE};
        v     = '{c, w, h, p, s};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= v[i];
            @(posedge clk);
            book.note_config(order[i], v[i]);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic move_to(logic [11:0] x, logic [12:0] y);
        btgr_pkg::in_item_t it;
        it         = rand_item();
        it.command = btgr_pkg::CMD_MOVE;
        it.new_x   = x;
        it.new_y   = y;
        push_item(it);
        pace();
    endtask

    // Load any glyph row not yet written, then draw the character
    task automatic draw_char(logic [7:0] code);
        btgr_pkg::in_item_t it;
        int unsigned        addr;
        for (int row = 0; row < GLYPH_ROWS; row++)
        begin
            addr = (int'(code) * int'(book.stride) + row) % FONT_BYTES;
            if (!book.loaded[addr])
            begin
                it              = rand_item();
                it.command      = btgr_pkg::CMD_LOAD;
                it.font_address = 12'(addr);
                push_item(it);
                pace();
            end
        end
        it           = rand_item();
        it.command   = btgr_pkg::CMD_DRAW;
        it.char_code = code;
        push_item(it);
        pace();
    endtask

    // One register setting followed by random traffic, drained halfway
    task automatic run_phase(logic [31:0] c, logic [31:0] w, logic [31:0] h,
                             logic [31:0] p, logic [31:0] s, int n);
        int                 stop;
        int                 mid;
        int                 r;
        bit                 pressed;
        logic [7:0]         code;
        btgr_pkg::in_item_t it;
        drain(24);
        write_regs(c, w, h, p, s);
        stop    = items_sent + n;
        mid     = items_sent + n / 2;
        pressed = 1'b0;
        while (items_sent < stop)
        begin
            if (!pressed && items_sent >= mid)
            begin
                drain(1);
                pressed = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    code = 8'hFF;
                else if (r < 20)
                    code = 8'h00;
                else if (r < 60 && recent.size() != 0)
                    code = recent[$urandom_range(0, recent.size() - 1)];
                else
                    code = 8'($urandom);
                draw_char(code);
                recent.push_back(code);
                if (recent.size() > 8)
                    void'(recent.pop_front());
            end
            else if (r < 78)
            begin
                move_to(($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, int'(book.width)))
                                                    : 12'($urandom),
                        ($urandom_range(0, 1) != 0) ? 13'($urandom_range(0, int'(book.height)))
                                                    : 13'($urandom));
            end
            else if (r < 90)
            begin
                // overwrite a random font byte, possibly inside a glyph in use
                it         = rand_item();
                it.command = btgr_pkg::CMD_LOAD;
                push_item(it);
                pace();
            end
            else
            begin
                it         = rand_item();
                it.command = CMD_UNUSED;
                push_item(it);
                pace();
            end
        end
    endtask

    initial
    begin
        logic [7:0]         patterns [17];
        btgr_pkg::in_item_t it;
        patterns = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'hAA, 8'h55, 8'h0F,
                     8'hF0, 8'h18, 8'h81, 8'h3C, 8'hC3, 8'h24, 8'h42, 8'h99};
        book = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stride one so two glyphs share the seventeen loaded bytes
        write_regs(32'hFFFF_FFFF, 32'd640, 32'd480, 32'd640, 32'd1);
        for (int a = 0; a < 17; a++)
        begin
            it              = rand_item();
            it.command      = btgr_pkg::CMD_LOAD;
            it.font_address = 12'(a);
            it.font_byte    = patterns[a];
            push_item(it);
            pace();
        end
        it              = rand_item();
        it.command      = btgr_pkg::CMD_LOAD;
        it.font_address = 12'hFFF;
        it.font_byte    = 8'hFF;
        push_item(it);
        pace();
        draw_char(8'd0);
        it         = rand_item();
        it.command = CMD_UNUSED;
        push_item(it);
        pace();
        // cursor at the far corner: rows below the screen, then wrap of x and y
        move_to(12'hFFF, 13'h1FFF);
        draw_char(8'd1);
        // last cell of a line that ends exactly at the screen height
        move_to(12'd632, 13'd464);
        draw_char(8'd0);
        draw_char(8'd1);

        // Random phases, extremes first
        run_phase($urandom, 32'd640, 32'd480, 32'd640, 32'd16, 40);
        run_phase(32'h0000_0000, 32'd8, 32'd16, 32'd8, 32'd1, 40);
        run_phase(32'hFFFF_FFFF, 32'd4096, 32'd4096, 32'd8192, 32'd16, 40);
        run_phase($urandom, $urandom_range(8, 4096), $urandom_range(16, 4096),
                  $urandom_range(8, 8192), $urandom_range(1, 16), 40);
        run_phase($urandom, $urandom_range(8, 4096), $urandom_range(16, 4096),
                  $urandom_range(8, 8192), $urandom_range(1, 16), 40);
        run_phase($urandom, 32'd12, 32'd16, 32'd8192, 32'd7, 40);

        drain(40);
        if (book.rows_due.size() != 0)
            book.report($sformatf("%0d rows never arrived", book.rows_due.size()));

        $display("Covered %0d items: %0d draws, %0d font loads, %0d cursor moves",
                 items_sent, book.draws, book.loads, book.moves);
        $display("over %0d register settings; %0d glyph rows checked",
                 settings, book.rows_seen);
        if (book.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d rows pending", book.rows_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* bitmap_text_glyph_renderer.f */
design/btgr_pkg.sv
design/btgr_ctrl.sv
design/btgr_datapath.sv
design/bitmap_text_glyph_renderer.sv
test/testbench.sv
